@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock, with or without an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/a2r_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2r_pkg
// Types and constants shared by the ARGB to RGB565 alpha plane converter.
// ----------------------------------------------------------------------------
package a2r_pkg;

  typedef enum logic [1:0] {
    FMT_4444 = 2'd0,
    FMT_1555 = 2'd1,
    FMT_8888 = 2'd2
  } fmt_t;

  localparam logic [1:0] CFG_IDX_FORMAT = 2'd0;
  localparam logic [1:0] CFG_IDX_DITHER = 2'd1;

  localparam logic [31:0] GEN_ADD = 32'h8765_4321;

  // Per-transaction control that every lane sees.
  typedef struct packed {
    fmt_t fmt;
    logic dith_en;
    logic opaque_pair;
  } lane_ctrl_t;

endpackage

@@ sv/a2r_dither.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2r_dither
// Rotate-xor-add dither generator; supplies the values for both lanes.
// ----------------------------------------------------------------------------
module a2r_dither import a2r_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_i,
  input  logic        clear_i,
  input  logic        adv_i,
  output logic [31:0] z0_o,
  output logic [31:0] z1_o
);

  logic [31:0] seed_r;
  logic [31:0] seed_nxt;
  logic [31:0] seed_eff;

  function automatic logic [31:0] gen_next(input logic [31:0] z);
    logic [31:0] t;
    t = z ^ {z[18:0], z[31:19]};
    return t + GEN_ADD;
  endfunction

  assign seed_eff = clear_i ? 32'd0 : seed_r;
  assign z0_o     = gen_next(seed_eff);
  assign z1_o     = gen_next(z0_o);

  always_comb begin
    seed_nxt = seed_r;
    if (step_i) begin
      seed_nxt = adv_i ? z1_o : seed_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

endmodule

@@ sv/a2r_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2r_lane
// Converts one source pixel into RGB565 and a 3-bit alpha.
// ----------------------------------------------------------------------------
module a2r_lane import a2r_pkg::*; (
  input  lane_ctrl_t  ctrl_i,
  input  logic [15:0] pix16_i,
  input  logic [31:0] pix32_i,
  input  logic [4:0]  z_i,
  output logic [15:0] rgb_o,
  output logic [2:0]  alpha_o
);

  logic [7:0] a8;
  logic [7:0] s;
  logic [2:0] dith_alpha;

  // Alpha scaled to 7/8; the low five bits decide the round-up against the dither.
  assign a8         = pix32_i[31:24];
  assign s          = a8 - {3'b000, a8[7:3]};
  assign dith_alpha = s[7:5] + {2'b00, (z_i < s[4:0])};

  always_comb begin
    rgb_o   = '0;
    alpha_o = '0;
    unique case (ctrl_i.fmt)
      FMT_4444: begin
        rgb_o   = {pix16_i[11:8], pix16_i[11], pix16_i[7:4], pix16_i[7:6],
                   pix16_i[3:0], pix16_i[3]};
        alpha_o = pix16_i[15:13];
      end
      FMT_1555: begin
        rgb_o   = {pix16_i[14:10], pix16_i[9:5], pix16_i[5], pix16_i[4:0]};
        alpha_o = {3{pix16_i[15]}};
      end
      FMT_8888: begin
        rgb_o = {pix32_i[23:19], pix32_i[15:10], pix32_i[7:3]};
        if (!ctrl_i.dith_en) begin
          alpha_o = pix32_i[31:29];
        end else if (ctrl_i.opaque_pair) begin
          alpha_o = 3'd7;
        end else begin
          alpha_o = dith_alpha;
        end
      end
      default: begin
        rgb_o   = '0;
        alpha_o = '0;
      end
    endcase
  end

endmodule

@@ sv/argb_to_rgb565_alpha_plane.sv @@
`timescale 1ns / 1ps
// Each result is registered and appears on the output in the cycle after its input
// is accepted. Throughput: one pixel pair per cycle while the output is not stalled,
// limited by the dither seed loop, which advances two generator steps combinationally.
// Reset (rst_n low, synchronous): output empty, format ARGB8888, dither on,
// dither seed zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
// argb_to_rgb565_alpha_plane
// Two conversion lanes, a shared dither generator and a merging output register.
// ----------------------------------------------------------------------------
module argb_to_rgb565_alpha_plane import a2r_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] pixel_word_a, [63:32] pixel_word_b
  input  logic        in_tuser,   // [0] region_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] rgb_pair, [38:32] alpha_pair, [39] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  fmt_t        fmt_r;
  logic        dith_en_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] rgb_r;
  logic [6:0]  alpha_r;

  logic        in_acc;
  logic [31:0] word_a;
  logic [31:0] word_b;
  lane_ctrl_t  ctrl;
  logic [31:0] z0;
  logic [31:0] z1;
  logic [15:0] rgb0;
  logic [15:0] rgb1;
  logic [2:0]  alpha0;
  logic [2:0]  alpha1;

  assign word_a    = in_tdata[31:0];
  assign word_b    = in_tdata[63:32];
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_8888;
      dith_en_r <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_FORMAT) begin
        fmt_r <= fmt_t'(cfg_data);
      end else if (cfg_index == CFG_IDX_DITHER) begin
        dith_en_r <= cfg_data[0];
      end
    end
  end

  assign ctrl.fmt         = fmt_r;
  assign ctrl.dith_en     = dith_en_r;
  assign ctrl.opaque_pair = ((word_a[31:24] & word_b[31:24]) == 8'hff);

  a2r_dither u_dither (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (in_acc),
    .clear_i (in_tuser),
    .adv_i   ((fmt_r == FMT_8888) && dith_en_r && !ctrl.opaque_pair),
    .z0_o    (z0),
    .z1_o    (z1)
  );

  a2r_lane u_lane0 (
    .ctrl_i  (ctrl),
    .pix16_i (word_a[15:0]),
    .pix32_i (word_a),
    .z_i     (z0[4:0]),
    .rgb_o   (rgb0),
    .alpha_o (alpha0)
  );

  a2r_lane u_lane1 (
    .ctrl_i  (ctrl),
    .pix16_i (word_a[31:16]),
    .pix32_i (word_b),
    .z_i     (z1[4:0]),
    .rgb_o   (rgb1),
    .alpha_o (alpha1)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Merge the lanes: first pixel in the low half and alpha bits 6:4.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rgb_r   <= {rgb1, rgb0};
      alpha_r <= {alpha0, 1'b0, alpha1};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, alpha_r, rgb_r};

endmodule

@@ sv/a2r_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2r_checker
// Port-level checks for the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a2r_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  property p_out_hold;
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata);
  endproperty

  property p_in_ready_empty;
    !out_tvalid |-> in_tready;
  endproperty

  property p_result_follows;
    in_tvalid && in_tready |=> out_tvalid;
  endproperty

  // Bit 35 is the gap between the two alpha fields and bit 39 is byte padding.
  property p_alpha_gap;
    out_tvalid |-> (out_tdata[35] == 1'b0) && (out_tdata[39] == 1'b0);
  endproperty

  `CHK_ASSERT(a_out_hold, clk, rst_n, p_out_hold, "stalled output changed")
  `CHK_ASSERT(a_in_ready_empty, clk, rst_n, p_in_ready_empty, "input stalled while output empty")
  `CHK_ASSERT(a_result_follows, clk, rst_n, p_result_follows, "accepted transaction gave no result")
  `CHK_ASSERT(a_alpha_gap, clk, rst_n, p_alpha_gap, "alpha gap or pad bit set")

endmodule

bind argb_to_rgb565_alpha_plane a2r_checker u_a2r_checker (.*);

@@ sim/argb_to_rgb565_alpha_plane_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_to_rgb565_alpha_plane_test
// Drives pixel pairs in every source format through the converter, with
// register writes between phases and random idling on both sides. A local
// predictor tracks format, dither switch and dither seed, and the monitor
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module argb_to_rgb565_alpha_plane_test;
  import a2r_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned REG_SETTLE  = 2;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned IDLE_PCT    = 16;
  localparam int unsigned CALM_FROM   = 300;
  localparam int unsigned CALM_TO     = 700;

  localparam logic [1:0] FMT_UNUSED      = 2'd3;
  localparam logic [1:0] CFG_IDX_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_IDX_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {
    OP_PIXELS,
    OP_REG_WRITE,
    OP_DRAIN
  } op_kind_t;

  typedef struct {
    op_kind_t    kind;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic        region_start;
    logic [1:0]  reg_index;
    logic [1:0]  reg_value;
  } pending_op_t;

  typedef struct packed {
    logic [31:0] rgb;
    logic [6:0]  alpha;
  } rgb_alpha_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [63:0] in_tdata   = '0;   // [31:0] pixel_word_a, [63:32] pixel_word_b
  logic        in_tuser   = 1'b0; // [0] region_start
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [1:0]  cfg_data   = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [39:0] out_tdata;         // [31:0] rgb_pair, [38:32] alpha_pair, [39] zero
  logic        cfg_ready;

  pending_op_t op_queue[$];
  rgb_alpha_t  expected_pairs[$];

  logic        in_taken  = 1'b0;
  logic        cfg_taken = 1'b0;
  int unsigned quiet_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_count = 0;

  // Predictor state.
  logic [1:0]  model_fmt    = FMT_8888;
  logic        model_dither = 1'b1;
  logic [31:0] model_seed   = '0;

  argb_to_rgb565_alpha_plane dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] seed_advance(logic [31:0] z);
    return (z ^ {z[18:0], z[31:19]}) + GEN_ADD;
  endfunction

  // Scale alpha to 7/8 and round up when the low five bits beat the dither value.
  function automatic logic [2:0] dithered_alpha(logic [7:0] a8, logic [31:0] z);
    logic [7:0] s;
    logic [3:0] v;
    s = a8 - {3'b000, a8[7:3]};
    v = {1'b0, s[7:5]} + ((z[4:0] < s[4:0]) ? 4'd1 : 4'd0);
    return v[2:0];
  endfunction

  function automatic logic [15:0] widen_4444(logic [15:0] p);
    return {p[11:8], p[11], p[7:4], p[7:6], p[3:0], p[3]};
  endfunction

  function automatic logic [15:0] widen_1555(logic [15:0] p);
    return {p[14:10], p[9:5], p[5], p[4:0]};
  endfunction

  function automatic logic [15:0] narrow_8888(logic [31:0] p);
    return {p[23:19], p[15:10], p[7:3]};
  endfunction

  function automatic rgb_alpha_t convert_pair(logic [31:0] a, logic [31:0] b,
                                              logic region_start);
    rgb_alpha_t  r;
    logic [31:0] z;
    r.rgb   = '0;
    r.alpha = '0;
    if (region_start)
      model_seed = '0;
    case (model_fmt)
      FMT_4444: begin
        r.rgb   = {widen_4444(a[31:16]), widen_4444(a[15:0])};
        r.alpha = {a[15:13], 1'b0, a[31:29]};
      end
      FMT_1555: begin
        r.rgb   = {widen_1555(a[31:16]), widen_1555(a[15:0])};
        r.alpha = {{3{a[15]}}, 1'b0, {3{a[31]}}};
      end
      FMT_8888: begin
        r.rgb = {narrow_8888(b), narrow_8888(a)};
        if (!model_dither) begin
          r.alpha = {a[31:29], 1'b0, b[31:29]};
        end else if ((a[31:24] & b[31:24]) == 8'hff) begin
          // A fully opaque pair leaves the seed where it is.
          r.alpha = {3'd7, 1'b0, 3'd7};
        end else begin
          z = seed_advance(model_seed);
          r.alpha[6:4] = dithered_alpha(a[31:24], z);
          z = seed_advance(z);
          r.alpha[2:0] = dithered_alpha(b[31:24], z);
          model_seed = z;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_pixels(logic [31:0] a, logic [31:0] b, logic region_start);
    pending_op_t op;
    op = '{OP_PIXELS, a, b, region_start, 2'd0, 2'd0};
    op_queue.push_back(op);
  endtask

  task automatic push_reg(logic [1:0] index, logic [1:0] value);
    pending_op_t op;
    op = '{OP_REG_WRITE, 32'd0, 32'd0, 1'b0, index, value};
    op_queue.push_back(op);
  endtask

  task automatic push_drain();
    pending_op_t op;
    op = '{OP_DRAIN, 32'd0, 32'd0, 1'b0, 2'd0, 2'd0};
    op_queue.push_back(op);
  endtask

  // Alpha leans toward fully opaque so that opaque pairs show up often.
  function automatic logic [31:0] random_argb();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: w[31:24] = 8'hff;
      4:          w[31:24] = 8'h00;
      default:    ;
    endcase
    return w;
  endfunction

  task automatic load_random(int unsigned count);
    repeat (count)
      push_pixels(random_argb(), random_argb(), $urandom_range(9) == 0);
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s", msg);
  endtask

  initial begin
    // Reset setting: ARGB8888 with dither on.
    push_pixels(32'h0000_0000, 32'h0000_0000, 1'b1);
    push_pixels(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    push_pixels(32'hff12_3456, 32'h00ab_cdef, 1'b0);
    push_pixels(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    push_pixels(32'h01ff_00ff, 32'hfe00_ff00, 1'b1);
    load_random(70);
    push_drain();
    load_random(70);

    push_reg(CFG_IDX_FORMAT, FMT_4444);
    push_pixels(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_pixels(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    push_pixels(32'h5555_aaaa, 32'h1234_5678, 1'b0);
    push_pixels(32'h8888_7777, 32'hffff_ffff, 1'b0);
    load_random(80);

    // Writes to unused indexes must leave both registers alone.
    push_reg(CFG_IDX_FORMAT, FMT_1555);
    push_reg(CFG_IDX_SPARE_2, 2'd3);
    push_reg(CFG_IDX_SPARE_3, 2'd0);
    push_pixels(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_pixels(32'hffff_ffff, 32'h0000_0000, 1'b0);
    push_pixels(32'h8000_7fff, 32'hffff_ffff, 1'b1);
    push_pixels(32'h7fff_8000, 32'h0000_0000, 1'b0);
    load_random(80);

    // Value 2 masks down to dither off.
    push_reg(CFG_IDX_DITHER, 2'd2);
    push_reg(CFG_IDX_FORMAT, FMT_8888);
    push_pixels(32'h0000_0000, 32'hffff_ffff, 1'b0);
    push_pixels(32'hffff_ffff, 32'h0000_0000, 1'b1);
    push_pixels(32'he0f8_fcf8, 32'h1f07_0307, 1'b0);
    push_pixels(32'h7f80_4020, 32'hdead_beef, 1'b0);
    load_random(80);

    // Unused format gives zeros, yet region start still clears the seed.
    push_reg(CFG_IDX_FORMAT, FMT_UNUSED);
    push_pixels(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    push_pixels(32'h1234_5678, 32'h9abc_def0, 1'b0);
    load_random(30);

    push_reg(CFG_IDX_DITHER, 2'd3);
    push_reg(CFG_IDX_FORMAT, FMT_8888);
    load_random(100);
    push_drain();
    load_random(100);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (op_queue.size() != 0 || in_tvalid || cfg_valid || expected_pairs.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("argb_to_rgb565_alpha_plane test passed");
    else
      $display("argb_to_rgb565_alpha_plane test failed");
    $finish;
  end

  // Driver: new transactions go out on the falling edge once the previous
  // one has been taken.
  always @(negedge clk) begin : driver
    logic calm;
    logic send_px;
    logic send_cfg;
    if (rst_n) begin
      calm = (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO);
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!(in_tvalid && !in_taken) && !(cfg_valid && !cfg_taken)) begin
        send_px  = 1'b0;
        send_cfg = 1'b0;
        if (op_queue.size() != 0) begin
          case (op_queue[0].kind)
            OP_PIXELS: begin
              if (calm || $urandom_range(99) >= IDLE_PCT) begin
                in_tdata <= {op_queue[0].word_b, op_queue[0].word_a};
                in_tuser <= op_queue[0].region_start;
                send_px = 1'b1;
                void'(op_queue.pop_front());
              end
            end
            OP_REG_WRITE: begin
              if (expected_pairs.size() == 0 && quiet_cnt >= REG_SETTLE) begin
                cfg_index <= op_queue[0].reg_index;
                cfg_data  <= op_queue[0].reg_value;
                send_cfg = 1'b1;
                void'(op_queue.pop_front());
              end
            end
            OP_DRAIN: begin
              if (expected_pairs.size() == 0)
                void'(op_queue.pop_front());
            end
            default: ;
          endcase
        end
        in_tvalid <= send_px;
        cfg_valid <= send_cfg;
      end
    end
  end

  // Monitor and predictor: everything on the rising edge.
  always @(posedge clk) begin : monitor
    rgb_alpha_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      model_fmt    = FMT_8888;
      model_dither = 1'b1;
      model_seed   = '0;
      in_taken  <= 1'b0;
      cfg_taken <= 1'b0;
      quiet_cnt <= 0;
    end else begin
      in_taken  <= in_tvalid && in_tready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_FORMAT)
          model_fmt = cfg_data;
        else if (cfg_index == CFG_IDX_DITHER)
          model_dither = cfg_data[0];
      end
      // Check before pushing, so a spurious result is never matched with
      // the transaction accepted on the same edge.
      if (out_tvalid && out_tready) begin
        if (expected_pairs.size() == 0) begin
          note_failure($sformatf("unexpected result: rgb_pair %h alpha_pair %h",
                                 out_tdata[31:0], out_tdata[38:32]));
        end else begin
          want = expected_pairs.pop_front();
          if (out_tdata[31:0] !== want.rgb)
            note_failure($sformatf("rgb_pair mismatch: expected %h, got %h",
                                   want.rgb, out_tdata[31:0]));
          if (out_tdata[38:32] !== want.alpha)
            note_failure($sformatf("alpha_pair mismatch: expected %h, got %h",
                                   want.alpha, out_tdata[38:32]));
        end
      end
      if (in_tvalid && in_tready)
        expected_pairs.push_back(convert_pair(in_tdata[31:0], in_tdata[63:32], in_tuser));
      quiet_cnt <= (expected_pairs.size() == 0 && !in_tvalid) ? quiet_cnt + 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("argb_to_rgb565_alpha_plane test failed");
      $finish;
    end
  end

endmodule

@@ files.f @@
+incdir+sv
sv/a2r_pkg.sv
sv/a2r_dither.sv
sv/a2r_lane.sv
sv/argb_to_rgb565_alpha_plane.sv
sv/a2r_checker.sv
sim/argb_to_rgb565_alpha_plane_test.sv
